// File: src/tpcc_pkg.sv
// Shared types and constants for the two-path conflict checker.
`timescale 1ns / 1ps

package tpcc_pkg;

  localparam int unsigned LOC_BITS = 20;

  typedef logic [LOC_BITS-1:0] loc_t;

  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_NORMAL = 2'd1,
    VERDICT_TARGET = 2'd2
  } verdict_t;

  typedef struct packed {
    loc_t loc_first;
    logic first_present;
    loc_t loc_second;
    logic second_present;
    logic last;
  } item_t;

endpackage

// File: src/tpcc_if.sv
// Channel interfaces for timestep items and verdicts.
`timescale 1ns / 1ps

interface tpcc_item_if;
  logic          valid;
  logic          ready;
  tpcc_pkg::loc_t loc_first;
  logic          first_present;
  tpcc_pkg::loc_t loc_second;
  logic          second_present;
  logic          last;

  modport source(output valid, output loc_first, output first_present,
                 output loc_second, output second_present, output last,
                 input ready);
  modport sink(input valid, input loc_first, input first_present,
               input loc_second, input second_present, input last,
               output ready);
endinterface

interface tpcc_verdict_if;
  logic               valid;
  logic               ready;
  tpcc_pkg::verdict_t verdict;

  modport source(output valid, output verdict, input ready);
  modport sink(input valid, input verdict, output ready);
endinterface

// File: src/tpcc_in_reg.sv
// Input register stage: captures one timestep transaction per cycle while the stage is empty or drains.
`timescale 1ns / 1ps

module tpcc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  tpcc_item_if.sink       in_item,
  output logic            item_vld,
  output tpcc_pkg::item_t item,
  input  logic            item_take
);

  logic            vld_r;
  logic            vld_nxt;
  tpcc_pkg::item_t item_r;
  logic            load;

  // Take a new transaction when the stage is empty or drains this cycle
  assign in_item.ready = !vld_r || item_take;
  assign load          = in_item.valid && in_item.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.loc_first      <= in_item.loc_first;
      item_r.first_present  <= in_item.first_present;
      item_r.loc_second     <= in_item.loc_second;
      item_r.second_present <= in_item.second_present;
      item_r.last           <= in_item.last;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: src/tpcc_eval.sv
// Conflict evaluation: path state, conflict flags and verdict register.
`timescale 1ns / 1ps

module tpcc_eval (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_vld,
  input  tpcc_pkg::item_t item,
  output logic            item_take,
  tpcc_verdict_if.source  out_verdict
);

  tpcc_pkg::loc_t     prev_first_r,  prev_first_nxt;
  tpcc_pkg::loc_t     prev_second_r, prev_second_nxt;
  logic               prev_both_r,   prev_both_nxt;
  tpcc_pkg::loc_t     parked_loc_r,  parked_loc_nxt;
  logic               parked_vld_r,  parked_vld_nxt;
  logic               normal_r,      normal_nxt;
  logic               target_r,      target_nxt;
  logic               out_vld_r,     out_vld_nxt;
  tpcc_pkg::verdict_t verdict_r,     verdict_nxt;

  logic           both;
  logic           one_only;
  logic           out_free;
  tpcc_pkg::loc_t running_loc;
  tpcc_pkg::loc_t park_cand;
  tpcc_pkg::loc_t parked_loc_upd;
  logic           parked_vld_upd;
  logic           normal_upd;
  logic           target_upd;

  // Advance a non-final item at once; a final item needs a free result slot
  assign out_free  = !out_vld_r || out_verdict.ready;
  assign item_take = item_vld && (!item.last || out_free);

  assign both        = item.first_present && item.second_present;
  assign one_only    = item.first_present ^ item.second_present;
  assign running_loc = item.first_present ? item.loc_first : item.loc_second;
  assign park_cand   = item.first_present ? prev_second_r : prev_first_r;

  // Work out the flags after this timestep
  always_comb begin
    normal_upd     = normal_r;
    target_upd     = target_r;
    parked_loc_upd = parked_loc_r;
    parked_vld_upd = parked_vld_r;
    if (both) begin
      if (item.loc_first == item.loc_second) begin
        normal_upd = 1'b1;
      end
      if (prev_both_r && prev_first_r == item.loc_second &&
          prev_second_r == item.loc_first) begin
        normal_upd = 1'b1;
      end
    end else if (one_only) begin
      // Park the final location of the agent that has just stopped
      if (prev_both_r) begin
        parked_loc_upd = park_cand;
        parked_vld_upd = 1'b1;
      end
      if (parked_vld_upd && running_loc == parked_loc_upd) begin
        target_upd = 1'b1;
      end
    end
  end

  // Commit state, clearing it once the verdict is issued
  always_comb begin
    prev_first_nxt  = prev_first_r;
    prev_second_nxt = prev_second_r;
    prev_both_nxt   = prev_both_r;
    parked_loc_nxt  = parked_loc_r;
    parked_vld_nxt  = parked_vld_r;
    normal_nxt      = normal_r;
    target_nxt      = target_r;
    out_vld_nxt     = out_vld_r;
    verdict_nxt     = verdict_r;
    if (out_verdict.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (item_take) begin
      if (item.last) begin
        prev_first_nxt  = '0;
        prev_second_nxt = '0;
        prev_both_nxt   = 1'b0;
        parked_loc_nxt  = '0;
        parked_vld_nxt  = 1'b0;
        normal_nxt      = 1'b0;
        target_nxt      = 1'b0;
        out_vld_nxt     = 1'b1;
        if (target_upd) begin
          verdict_nxt = tpcc_pkg::VERDICT_TARGET;
        end else if (normal_upd) begin
          verdict_nxt = tpcc_pkg::VERDICT_NORMAL;
        end else begin
          verdict_nxt = tpcc_pkg::VERDICT_NONE;
        end
      end else begin
        prev_first_nxt  = item.loc_first;
        prev_second_nxt = item.loc_second;
        prev_both_nxt   = both;
        parked_loc_nxt  = parked_loc_upd;
        parked_vld_nxt  = parked_vld_upd;
        normal_nxt      = normal_upd;
        target_nxt      = target_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_first_r  <= '0;
      prev_second_r <= '0;
      prev_both_r   <= 1'b0;
      parked_loc_r  <= '0;
      parked_vld_r  <= 1'b0;
      normal_r      <= 1'b0;
      target_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      prev_first_r  <= prev_first_nxt;
      prev_second_r <= prev_second_nxt;
      prev_both_r   <= prev_both_nxt;
      parked_loc_r  <= parked_loc_nxt;
      parked_vld_r  <= parked_vld_nxt;
      normal_r      <= normal_nxt;
      target_r      <= target_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // Hold the verdict payload while the receiver stalls
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  assign out_verdict.valid   = out_vld_r;
  assign out_verdict.verdict = verdict_r;

endmodule

// File: src/two_path_conflict_checker_core.sv
// Two-path conflict checker: top level.
//
// Usage: feed one timestep transaction per cycle on in_item (both agents'
// locations, their presence flags and a last flag on the final timestep).
// Within the common prefix a shared location or a swap between consecutive
// timesteps is a vertex/edge conflict; once one path ends its final
// location is parked and a later visit by the other agent is a target
// conflict. On the last transaction one verdict leaves on out_verdict:
// none, vertex/edge, or target (target outranks vertex/edge). State then
// clears for the next pair of paths.
// Throughput: one transaction per cycle while no final transaction is stalled,
// set by the input register and the combinational compare logic in front of the verdict register.
// Result path: once the last transaction is accepted it passes through the
// input register and then the verdict register before the verdict is valid.
// Reset: synchronous, active low; clears all path state and both valids.
// Stall: while a verdict waits, non-final transactions keep flowing; a
// further final transaction waits in the input register until the verdict
// is taken, and in_item.ready then drops.
`timescale 1ns / 1ps

module two_path_conflict_checker_core (
  input  logic           clk,
  input  logic           rst_n,
  tpcc_item_if.sink      in_item,
  tpcc_verdict_if.source out_verdict
);

  logic            item_vld;
  logic            item_take;
  tpcc_pkg::item_t item;

  tpcc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  tpcc_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (item_vld),
    .item        (item),
    .item_take   (item_take),
    .out_verdict (out_verdict)
  );

endmodule
